// ===== rtl/core/nlms_pkg.sv =====
// ----------------------------------------------------------------------------
// NLMS package
// Shared types and constants for the block NLMS adaptive filter core.
// ----------------------------------------------------------------------------
package nlms_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 24;
    localparam int STEP_W   = 16;
    localparam int ENERGY_W = 40;
    localparam int GAIN_W   = 45;   // step << 38 divided by at least 1074
    localparam int DOT_W    = 48;

    localparam logic [ENERGY_W-1:0] REG_Q30     = 40'd1074;
    localparam logic [WEIGHT_W-1:0] WEIGHT_INIT = 24'd10486;
    localparam logic [STEP_W-1:0]   STEP_RESET  = 16'd3277;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // write one sample and add its square
        logic div_start;    // begin the gain division
        logic dot_clear;    // clear the dot accumulator
        logic dot_acc;      // accumulate one weight times sample
        logic err_calc;     // form the error of the current pass
        logic gain_mul;     // form the per-pass update coefficient
        logic upd;          // update one weight
        logic blk_clear;    // clear the energy after the block
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

endpackage

// ===== rtl/core/nlms_block_adaptive_filter_core.sv =====
// ----------------------------------------------------------------------------
// Block NLMS adaptive filter core
// Loads BLOCK_LEN samples, divides step by energy once, then runs BLOCK_LEN
// passes of dot product, error output and weight update.
// ----------------------------------------------------------------------------
// The completing sample is followed by the gain division, then BLOCK_LEN
// passes, each accumulating the dot product over the weight memory, forming
// the error and the update coefficient, then updating every weight; each pass
// emits one error item. No new sample is taken until the block's passes end.
// Reset (synchronous, active low) restores step size, weights and counts;
// results cannot be stalled, each is shown for exactly one cycle.
module nlms_block_adaptive_filter_core
    import nlms_pkg::*;
#(
    parameter int BLOCK_LEN = 64
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_strobe,
    output logic [SAMPLE_W-1:0] o_error,
    output logic [5:0]          o_position,
    output logic                o_last,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [STEP_W-1:0]   i_cfg_data
);

    localparam int IDX_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

    logic [STEP_W-1:0] r_step;
    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [IDX_W-1:0]  w_idx;
    logic [IDX_W-1:0]  w_rd_idx;
    logic [IDX_W-1:0]  w_pass;
    logic              w_busy;

    // The step size register takes writes only while the core waits for
    // samples, so a block in its passes never sees the step change.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_cfg_valid && !w_busy) begin
            r_step <= i_cfg_data;
        end
    end

    assign o_cfg_ready = !w_busy;

    nlms_ctrl #(
        .BLOCK_LEN (BLOCK_LEN),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_idx    (w_idx),
        .o_rd_idx (w_rd_idx),
        .o_pass   (w_pass),
        .o_busy   (w_busy),
        .o_strobe (o_strobe),
        .o_last   (o_last)
    );

    nlms_dp #(
        .BLOCK_LEN (BLOCK_LEN),
        .IDX_W     (IDX_W)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_idx    (w_idx),
        .i_rd_idx (w_rd_idx),
        .i_pass   (w_pass),
        .i_step   (r_step),
        .i_sample (i_sample),
        .o_stat   (w_stat),
        .o_error  (o_error)
    );

    assign busy       = w_busy;
    assign o_position = 6'(w_pass);

endmodule

// ===== rtl/core/nlms_div.sv =====
// ----------------------------------------------------------------------------
// NLMS divider
// Restoring divider, one quotient bit per cycle: gain = (step << 38) / energy.
// ----------------------------------------------------------------------------
module nlms_div
    import nlms_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [STEP_W-1:0]   i_step,
    input  logic [ENERGY_W-1:0] i_energy,
    output logic                o_done,
    output logic [GAIN_W-1:0]   o_gain
);

    localparam int NUM_W = STEP_W + 38;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]    r_num;
    logic [ENERGY_W:0]   r_rem;
    logic [NUM_W-1:0]    r_quo;
    logic [ENERGY_W-1:0] r_den;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [ENERGY_W:0]   n_shift;
    logic [ENERGY_W:0]   n_diff;

    assign n_shift = {r_rem[ENERGY_W-1:0], r_num[NUM_W-1]};
    assign n_diff  = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_num  <= {i_step, 38'd0};
                r_rem  <= '0;
                r_quo  <= '0;
                r_den  <= i_energy;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                if (!n_diff[ENERGY_W]) begin
                    r_rem <= n_diff;
                    r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gain = r_quo[GAIN_W-1:0];

endmodule

// ===== rtl/core/nlms_dp.sv =====
// ----------------------------------------------------------------------------
// NLMS datapath
// Sample and weight memories, energy sum, dot product, error and update math.
// ----------------------------------------------------------------------------
module nlms_dp
    import nlms_pkg::*;
#(
    parameter int BLOCK_LEN = 64,
    parameter int IDX_W     = 6
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [IDX_W-1:0]    i_idx,      // load address or weight index
    input  logic [IDX_W-1:0]    i_rd_idx,   // index of the next cycle
    input  logic [IDX_W-1:0]    i_pass,
    input  logic [STEP_W-1:0]   i_step,
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_stat               o_stat,
    output logic [SAMPLE_W-1:0] o_error
);

    logic signed [SAMPLE_W-1:0] r_smem [BLOCK_LEN];
    logic signed [WEIGHT_W-1:0] r_wmem [BLOCK_LEN];
    logic [BLOCK_LEN-1:0]       r_wvalid;
    logic [ENERGY_W-1:0]        r_energy;
    logic signed [DOT_W-1:0]    r_dot;
    logic signed [SAMPLE_W-1:0] r_err;
    logic signed [40:0]         r_coef;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_xn;
    logic signed [WEIGHT_W-1:0] r_wrd;
    logic                       r_wv;
    logic [GAIN_W-1:0]          w_gain;
    logic                       w_div_done;

    logic signed [SAMPLE_W-1:0] w_x;
    logic signed [WEIGHT_W-1:0] w_w;
    logic signed [39:0]         w_prod;
    logic signed [DOT_W:0]      w_ediff;
    logic signed [DOT_W:0]      w_eround;
    logic signed [DOT_W:0]      w_esat;
    logic signed [71:0]         w_gprod;
    logic signed [71:0]         w_graw;
    logic signed [57:0]         w_cprod;
    logic signed [57:0]         w_dlt;
    logic signed [58:0]         w_wsum;
    logic signed [WEIGHT_W-1:0] n_w;
    logic signed [31:0]         w_sq;

    nlms_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_step   (i_step),
        .i_energy (r_energy + REG_Q30),
        .o_done   (w_div_done),
        .o_gain   (w_gain)
    );

    // Memory reads are registered at the index of the next cycle, so the data
    // for the current index is present while that index is worked on.
    assign w_x    = r_x;
    assign w_w    = r_wv ? r_wrd : $signed(WEIGHT_INIT);
    assign w_prod = w_w * w_x;
    assign w_sq   = $signed(i_sample) * $signed(i_sample);

    // Error: (x[n] << 20 - dot) rounded at bit 20, saturated.
    assign w_ediff  = ($signed({{(DOT_W-SAMPLE_W-20+1){r_xn[SAMPLE_W-1]}},
                        r_xn, 20'd0})) - (DOT_W+1)'(r_dot);
    assign w_eround = (w_ediff + (DOT_W+1)'(1 << 19)) >>> 20;
    assign w_esat   = (w_eround > 32767) ? (DOT_W+1)'(32767) :
                      (w_eround < -32768) ? -(DOT_W+1)'(32768) : w_eround;

    assign w_gprod = $signed({1'b0, w_gain}) * r_err;
    assign w_graw  = (w_gprod + 72'sd262144) >>> 19;

    assign w_cprod = r_coef * w_x;
    assign w_dlt   = (w_cprod + 58'sd16384) >>> 15;
    assign w_wsum  = 59'(w_w) + 59'(w_dlt);
    assign n_w     = (w_wsum > 59'sd8388607) ? 24'sh7FFFFF :
                     (w_wsum < -59'sd8388608) ? 24'sh800000 : w_wsum[WEIGHT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
            r_energy <= '0;
        end else begin
            if (i_cmd.load) begin
                r_energy <= r_energy + ENERGY_W'($unsigned(w_sq));
            end else if (i_cmd.blk_clear) begin
                r_energy <= '0;
            end
            if (i_cmd.upd) begin
                r_wvalid[i_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_smem[i_idx] <= i_sample;
        end
        if (i_cmd.upd) begin
            r_wmem[i_idx] <= n_w;
        end
        r_x   <= r_smem[i_rd_idx];
        r_xn  <= r_smem[i_pass];
        r_wrd <= r_wmem[i_rd_idx];
        r_wv  <= r_wvalid[i_rd_idx];
        if (i_cmd.dot_clear) begin
            r_dot <= '0;
        end else if (i_cmd.dot_acc) begin
            r_dot <= r_dot + DOT_W'(w_prod);
        end
        if (i_cmd.err_calc) begin
            r_err <= w_esat[SAMPLE_W-1:0];
        end
        if (i_cmd.gain_mul) begin
            r_coef <= w_graw[40:0];
        end
    end

    assign o_stat.div_done = w_div_done;
    assign o_error         = r_err;

endmodule

// ===== rtl/core/nlms_ctrl.sv =====
// ----------------------------------------------------------------------------
// NLMS controller
// Sequences loading, the gain division and the dot/update passes.
// ----------------------------------------------------------------------------
module nlms_ctrl
    import nlms_pkg::*;
#(
    parameter int BLOCK_LEN = 64,
    parameter int IDX_W     = 6
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_stat            i_stat,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_idx,
    output logic [IDX_W-1:0] o_rd_idx,
    output logic [IDX_W-1:0] o_pass,
    output logic             o_busy,
    output logic             o_strobe,
    output logic             o_last
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_DOT  = 3'd2;
    localparam logic [2:0] S_ERR  = 3'd3;
    localparam logic [2:0] S_GAIN = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_LEN - 1);

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_pass, n_pass;
    logic             r_strobe, n_strobe;
    t_cmd             w_cmd;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pass   = r_pass;
        n_strobe = 1'b0;
        w_cmd    = '0;
        case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_DIV;
                        w_cmd.div_start = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DIV: begin
                // The energy register already holds the full sum here.
                if (i_stat.div_done) begin
                    n_state         = S_DOT;
                    n_idx           = '0;
                    n_pass          = '0;
                    w_cmd.dot_clear = 1'b1;
                end
            end
            S_DOT: begin
                w_cmd.dot_acc = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_ERR;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_ERR: begin
                w_cmd.err_calc = 1'b1;
                n_state        = S_GAIN;
                n_strobe       = 1'b1;
            end
            S_GAIN: begin
                w_cmd.gain_mul = 1'b1;
                n_state        = S_UPD;
            end
            S_UPD: begin
                w_cmd.upd = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx = '0;
                    if (r_pass == LAST_IDX) begin
                        n_state         = S_LOAD;
                        w_cmd.blk_clear = 1'b1;
                    end else begin
                        n_pass          = r_pass + 1'b1;
                        n_state         = S_DOT;
                        w_cmd.dot_clear = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_LOAD;
                n_idx   = '0;
            end
        endcase
    end

    // A separate registered pulse starts the divider on entry to S_DIV, when
    // the last square has already landed in the energy register.
    logic r_div_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_idx    <= '0;
            r_pass   <= '0;
            r_strobe <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pass   <= n_pass;
            r_strobe <= n_strobe;
            r_div_go <= (r_state == S_LOAD) && (n_state == S_DIV);
        end
    end

    always_comb begin
        o_cmd           = w_cmd;
        o_cmd.div_start = r_div_go;
    end

    assign o_idx    = r_idx;
    assign o_rd_idx = n_idx;
    assign o_pass   = r_pass;
    assign o_busy   = (r_state != S_LOAD);
    assign o_strobe = r_strobe;
    assign o_last   = r_strobe && (r_pass == LAST_IDX);

endmodule

// ===== rtl/core/nlms_checker.sv =====
// ----------------------------------------------------------------------------
// NLMS port checker
// Watches the top-level ports for ordering of result items.
// ----------------------------------------------------------------------------
module nlms_checker #(
    parameter int BLOCK_LEN = 64
)
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_strobe,
    input logic [5:0] o_position,
    input logic       o_last
);

    a_last_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe) else $error("last without strobe");

    a_strobe_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy) else $error("result while idle");

    a_no_double_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("back to back results");

    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> (o_position == 6'(BLOCK_LEN - 1)))
        else $error("last flag on wrong position");

    a_inner_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> (o_position != 6'(BLOCK_LEN - 1)))
        else $error("final position without last flag");

endmodule

bind nlms_block_adaptive_filter_core nlms_checker #(.BLOCK_LEN(BLOCK_LEN)) u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_position (o_position),
    .o_last     (o_last)
);
